### design/ats_pkg.sv
package ats_pkg;

	// Characters with special meaning in a template
	localparam logic [15:0] CH_LBRACE = 16'h007B;
	localparam logic [15:0] CH_RBRACE = 16'h007D;
	localparam logic [15:0] CH_APOS   = 16'h0027;
	localparam logic [15:0] CH_QUOTE  = 16'h0022;

	// Most result words one input word can cause
	localparam int unsigned BATCH_MAX = 3;

	typedef enum logic [2:0] {
		MODE_OUT     = 3'd0,
		MODE_OUT_LB  = 3'd1,
		MODE_OUT_RB  = 3'd2,
		MODE_EXPR    = 3'd3,
		MODE_EXPR_Q  = 3'd4,
		MODE_DISCARD = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KIND_LIT      = 3'd0,
		KIND_EXPR     = 3'd1,
		KIND_LIT_END  = 3'd2,
		KIND_EXPR_END = 3'd3,
		KIND_ERROR    = 3'd4,
		KIND_TMPL_END = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_MISSING     = 2'd1,
		ERR_UNMATCHED_RB = 2'd2,
		ERR_LB_IN_EXPR  = 2'd3
	} err_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
	} unit_word_t;

	typedef struct packed {
		logic [15:0] out_unit;
		kind_t       item_kind;
		err_t        error_code;
		logic        last_of_run;
	} result_word_t;

	// Results of one input word, in order, res[0] first
	typedef struct packed {
		logic [1:0]                     count;
		result_word_t [BATCH_MAX-1:0]   res;
	} batch_t;

	function automatic result_word_t mk_result(logic [15:0] unit, kind_t kind, err_t err);
		result_word_t r;
		r.out_unit    = unit;
		r.item_kind   = kind;
		r.error_code  = err;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

### design/ats_parse.sv
module ats_parse
	import ats_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  unit_word_t word,
	input  logic       advance,
	output batch_t     batch
);

	mode_t mode_q;
	logic  quote_mark_q;  // open stretch uses quote mark (else apostrophe)
	logic  lit_open_q;
	logic  first_q;

	mode_t mode_d;
	logic  quote_mark_d;
	logic  lit_open_d;
	logic  first_d;

	always_comb begin
		logic [1:0]                   n;
		result_word_t [BATCH_MAX-1:0] res;
		logic [15:0]                  c;
		logic                         fin;
		logic                         is_quote;
		logic [15:0]                  close_ch;

		n            = 2'd0;
		res          = '0;
		c            = word.code_unit;
		fin          = word.final_unit;
		is_quote     = (c == CH_APOS) || (c == CH_QUOTE);
		close_ch     = quote_mark_q ? CH_QUOTE : CH_APOS;
		mode_d       = mode_q;
		quote_mark_d = quote_mark_q;
		lit_open_d   = lit_open_q;
		first_d      = first_q;

		if (first_q && fin) begin
			// one-unit template is always literal
			res[0]       = mk_result(c, KIND_LIT, ERR_NONE);
			res[1]       = mk_result(16'd0, KIND_LIT_END, ERR_NONE);
			res[2]       = mk_result(16'd0, KIND_TMPL_END, ERR_NONE);
			n            = 2'd3;
			mode_d       = MODE_OUT;
			quote_mark_d = 1'b0;
			lit_open_d   = 1'b0;
			first_d      = 1'b1;
		end else begin
			first_d = 1'b0;
			unique case (mode_q)
				MODE_OUT_LB: begin
					if (c == CH_LBRACE) begin
						res[n]     = mk_result(c, KIND_LIT, ERR_NONE);
						n          = n + 2'd1;
						lit_open_d = 1'b1;
						mode_d     = MODE_OUT;
					end else begin
						if (lit_open_q) begin
							res[n]     = mk_result(16'd0, KIND_LIT_END, ERR_NONE);
							n          = n + 2'd1;
							lit_open_d = 1'b0;
						end
						if (c == CH_RBRACE) begin
							res[n] = mk_result(16'd0, KIND_EXPR_END, ERR_NONE);
							n      = n + 2'd1;
							mode_d = MODE_OUT;
						end else begin
							res[n] = mk_result(c, KIND_EXPR, ERR_NONE);
							n      = n + 2'd1;
							if (is_quote) begin
								quote_mark_d = (c == CH_QUOTE);
								mode_d       = MODE_EXPR_Q;
							end else begin
								mode_d = MODE_EXPR;
							end
						end
					end
				end
				MODE_OUT_RB: begin
					if (c == CH_RBRACE) begin
						res[n]     = mk_result(c, KIND_LIT, ERR_NONE);
						n          = n + 2'd1;
						lit_open_d = 1'b1;
						mode_d     = MODE_OUT;
					end else begin
						res[n] = mk_result(16'd0, KIND_ERROR, ERR_UNMATCHED_RB);
						n      = n + 2'd1;
						mode_d = MODE_DISCARD;
					end
				end
				MODE_EXPR: begin
					if (c == CH_RBRACE) begin
						res[n] = mk_result(16'd0, KIND_EXPR_END, ERR_NONE);
						n      = n + 2'd1;
						mode_d = MODE_OUT;
					end else if (c == CH_LBRACE) begin
						res[n] = mk_result(16'd0, KIND_ERROR, ERR_LB_IN_EXPR);
						n      = n + 2'd1;
						mode_d = MODE_DISCARD;
					end else begin
						res[n] = mk_result(c, KIND_EXPR, ERR_NONE);
						n      = n + 2'd1;
						if (is_quote) begin
							quote_mark_d = (c == CH_QUOTE);
							mode_d       = MODE_EXPR_Q;
						end
					end
				end
				MODE_EXPR_Q: begin
					res[n] = mk_result(c, KIND_EXPR, ERR_NONE);
					n      = n + 2'd1;
					if (c == close_ch) begin
						quote_mark_d = 1'b0;
						mode_d       = MODE_EXPR;
					end
				end
				MODE_DISCARD: begin
				end
				default: begin
					if (c == CH_LBRACE) begin
						mode_d = MODE_OUT_LB;
					end else if (c == CH_RBRACE) begin
						mode_d = MODE_OUT_RB;
					end else begin
						res[n]     = mk_result(c, KIND_LIT, ERR_NONE);
						n          = n + 2'd1;
						lit_open_d = 1'b1;
						mode_d     = MODE_OUT;
					end
				end
			endcase

			if (fin) begin
				if (mode_d == MODE_OUT) begin
					if (lit_open_d && n != 2'd3) begin
						res[n] = mk_result(16'd0, KIND_LIT_END, ERR_NONE);
						n      = n + 2'd1;
					end
					if (n != 2'd3) begin
						res[n] = mk_result(16'd0, KIND_TMPL_END, ERR_NONE);
						n      = n + 2'd1;
					end
				end else if (mode_d != MODE_DISCARD && n != 2'd3) begin
					res[n] = mk_result(16'd0, KIND_ERROR, ERR_MISSING);
					n      = n + 2'd1;
				end
				mode_d       = MODE_OUT;
				quote_mark_d = 1'b0;
				lit_open_d   = 1'b0;
				first_d      = 1'b1;
			end
		end

		if (n != 2'd0) begin
			res[n - 2'd1].last_of_run = 1'b1;
		end
		batch.count = n;
		batch.res   = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OUT;
			quote_mark_q <= 1'b0;
			lit_open_q   <= 1'b0;
			first_q      <= 1'b1;
		end else if (advance) begin
			mode_q       <= mode_d;
			quote_mark_q <= quote_mark_d;
			lit_open_q   <= lit_open_d;
			first_q      <= first_d;
		end
	end

endmodule

### design/ats_outbuf.sv
module ats_outbuf
	import ats_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  batch_t       batch,
	output logic         free,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result_data
);

	logic [1:0]                   cnt_q;
	result_word_t [BATCH_MAX-1:0] res_q;
	logic                         pop;

	assign result_valid = (cnt_q != 2'd0);
	assign result_data  = res_q[0];
	assign pop          = result_valid && result_ready;
	// empty now, or last pending word leaves this cycle
	assign free         = (cnt_q == 2'd0) || (cnt_q == 2'd1 && result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

### design/attribute_template_splitter.sv
// Channel   Handshake                    Word             Moves
// unit      unit_valid / unit_ready      unit_word_t      one code unit + final flag
// result    result_valid / result_ready  result_word_t    one tagged char or marker
//
// A code unit waits in the input register, then is parsed in a
// single pass and its 0 to 3 result words load the output buffer.
// Throughput is one code unit per cycle while each unit gives at most one
// word and result_ready is high; after a unit giving more, the next waits in
// the input register as the buffer drains one word per ready cycle.
// Reset (arst_n low) empties both stages and returns to the start of a template.
// A stalled result side backs up into the input register, then unit_ready.
module attribute_template_splitter
	import ats_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         unit_valid,
	output logic         unit_ready,
	input  unit_word_t   unit_data,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result_data
);

	logic       valid_s1;
	unit_word_t word_s1;

	batch_t batch;
	logic   buf_free;
	logic   consume;

	// Input word leaves s1 once the output buffer can take all its results
	assign consume    = valid_s1 && buf_free;
	assign unit_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (unit_valid && unit_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (unit_valid && unit_ready) begin
			word_s1 <= unit_data;
		end
	end

	// Template parser: brace/quote state advances only when its results are taken
	ats_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.word    (word_s1),
		.advance (consume),
		.batch   (batch)
	);

	// Result register: holds a batch, hands out one word per ready cycle
	ats_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (consume),
		.batch        (batch),
		.free         (buf_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

### tb/sv/tb_attribute_template_splitter.sv
`timescale 1ns / 100ps

module tb_attribute_template_splitter;
	import ats_pkg::*;

	// Idle cycles in a row before the run is declared hung. The longest legal
	// quiet stretch is the long receiver hold plus one sender gap.
	localparam int unsigned HANG_LIMIT = 2000;
	// Cycles the receiver holds off in the back-pressure test
	localparam int unsigned LONG_HOLD  = 250;

	// Scoreboard: tracks the template parse state, turns each accepted code unit
	// into the result words it must cause, then checks them in order.
	class split_scoreboard;
		mode_t          mode;
		logic [15:0]    open_quote;
		bit             literal_open;
		bit             at_first;
		result_word_t   batch[$];
		result_word_t   expected_words[$];
		int unsigned    fails;

		function new();
			fails = 0;
			clear_template();
		endfunction

		function void clear_template();
			mode         = MODE_OUT;
			open_quote   = '0;
			literal_open = 1'b0;
			at_first     = 1'b1;
		endfunction

		function void add(logic [15:0] u, kind_t k, err_t e);
			result_word_t r;
			r.out_unit    = u;
			r.item_kind   = k;
			r.error_code  = e;
			r.last_of_run = 1'b0;
			batch.push_back(r);
		endfunction

		function bit quote_char(logic [15:0] c);
			return (c == CH_APOS) || (c == CH_QUOTE);
		endfunction

		// Works out the result words of one accepted unit. Returns 1 when the
		// unit falls in the discard stretch after an error.
		function bit predict_unit(unit_word_t w);
			logic [15:0] c;
			bit          fin;
			bit          dropped;
			c       = w.code_unit;
			fin     = w.final_unit;
			dropped = (mode == MODE_DISCARD);
			batch.delete();
			if (at_first && fin) begin
				// single-unit template is literal whatever it holds
				add(c, KIND_LIT, ERR_NONE);
				add('0, KIND_LIT_END, ERR_NONE);
				add('0, KIND_TMPL_END, ERR_NONE);
				clear_template();
			end else begin
				at_first = 1'b0;
				case (mode)
					MODE_OUT_LB: begin
						if (c == CH_LBRACE) begin
							// doubled left brace
							add(c, KIND_LIT, ERR_NONE);
							literal_open = 1'b1;
							mode         = MODE_OUT;
						end else begin
							if (literal_open) begin
								add('0, KIND_LIT_END, ERR_NONE);
								literal_open = 1'b0;
							end
							if (c == CH_RBRACE) begin
								// empty expression
								add('0, KIND_EXPR_END, ERR_NONE);
								mode = MODE_OUT;
							end else begin
								add(c, KIND_EXPR, ERR_NONE);
								if (quote_char(c)) begin
									open_quote = c;
									mode       = MODE_EXPR_Q;
								end else begin
									mode = MODE_EXPR;
								end
							end
						end
					end
					MODE_OUT_RB: begin
						if (c == CH_RBRACE) begin
							add(c, KIND_LIT, ERR_NONE);
							literal_open = 1'b1;
							mode         = MODE_OUT;
						end else begin
							add('0, KIND_ERROR, ERR_UNMATCHED_RB);
							mode = MODE_DISCARD;
						end
					end
					MODE_EXPR: begin
						if (c == CH_RBRACE) begin
							add('0, KIND_EXPR_END, ERR_NONE);
							mode = MODE_OUT;
						end else if (c == CH_LBRACE) begin
							add('0, KIND_ERROR, ERR_LB_IN_EXPR);
							mode = MODE_DISCARD;
						end else begin
							add(c, KIND_EXPR, ERR_NONE);
							if (quote_char(c)) begin
								open_quote = c;
								mode       = MODE_EXPR_Q;
							end
						end
					end
					MODE_EXPR_Q: begin
						add(c, KIND_EXPR, ERR_NONE);
						if (c == open_quote) begin
							open_quote = '0;
							mode       = MODE_EXPR;
						end
					end
					MODE_DISCARD: ;
					default: begin
						if (c == CH_LBRACE) begin
							mode = MODE_OUT_LB;
						end else if (c == CH_RBRACE) begin
							mode = MODE_OUT_RB;
						end else begin
							add(c, KIND_LIT, ERR_NONE);
							literal_open = 1'b1;
							mode         = MODE_OUT;
						end
					end
				endcase
				if (fin) begin
					if (mode == MODE_OUT) begin
						if (literal_open)
							add('0, KIND_LIT_END, ERR_NONE);
						add('0, KIND_TMPL_END, ERR_NONE);
					end else if (mode != MODE_DISCARD) begin
						// brace or quote still open at the end
						add('0, KIND_ERROR, ERR_MISSING);
					end
					clear_template();
				end
			end
			if (batch.size() > 0)
				batch[batch.size()-1].last_of_run = 1'b1;
			foreach (batch[i])
				expected_words.push_back(batch[i]);
			return dropped;
		endfunction

		function void check_word(result_word_t got);
			result_word_t exp;
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: unit %h kind %0d err %0d last %0d",
					got.out_unit, got.item_kind, got.error_code, got.last_of_run);
				fails++;
				return;
			end
			exp = expected_words.pop_front();
			if (got.out_unit !== exp.out_unit) begin
				$error("out_unit: expected %h, got %h", exp.out_unit, got.out_unit);
				fails++;
			end
			if (got.item_kind !== exp.item_kind) begin
				$error("item_kind: expected %0d, got %0d", exp.item_kind, got.item_kind);
				fails++;
			end
			if (got.error_code !== exp.error_code) begin
				$error("error_code: expected %0d, got %0d", exp.error_code, got.error_code);
				fails++;
			end
			if (got.last_of_run !== exp.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", exp.last_of_run, got.last_of_run);
				fails++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         unit_valid;
	logic         unit_ready;
	unit_word_t   unit_data;
	logic         result_valid;
	logic         result_ready;
	result_word_t result_data;

	split_scoreboard sb;

	bit           tx_gaps;        // sender may idle between words
	bit           rx_gaps;        // receiver may stall
	bit           hold_req;       // ask the receiver for one long hold-off
	int unsigned  units_parsed;   // accepted units outside the discard stretch
	int unsigned  idle_cycles;
	logic [15:0]  tmpl[$];        // code units of the template being sent

	attribute_template_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.unit_valid   (unit_valid),
		.unit_ready   (unit_ready),
		.unit_data    (unit_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Result side: every word accepted at a rising edge goes to the scoreboard.
	// Reads right after the edge see the values from before it.
	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.check_word(result_data);
	end

	// Hang detector: any accepted word on either channel restarts the count.
	always @(posedge clk) begin
		if ((unit_valid && unit_ready) || (result_valid && result_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$error("no word accepted for %0d cycles", HANG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: ready changes at the falling edge only. Random stall bursts,
	// plus one long hold-off on request so the block backs up into its input.
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Offers one word and returns at the edge that takes it. Valid stays high
	// afterward; the next call either replaces the word or drops valid for a gap.
	task automatic send_unit(input unit_word_t w);
		int gap;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			unit_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		unit_valid <= 1'b1;
		unit_data  <= w;
		do
			@(posedge clk);
		while (!unit_ready);
		if (!sb.predict_unit(w))
			units_parsed++;
	endtask

	// Sends tmpl[] as one template, final flag on its last unit
	task automatic send_template();
		unit_word_t w;
		foreach (tmpl[i]) begin
			w.code_unit  = tmpl[i];
			w.final_unit = (i == tmpl.size() - 1);
			send_unit(w);
		end
	endtask

	task automatic send_text(input string s);
		tmpl.delete();
		for (int i = 0; i < s.len(); i++)
			tmpl.push_back({8'h00, s[i]});
		send_template();
	endtask

	// Drops valid, then waits until every expected word has arrived
	task automatic wait_drained();
		int n;
		n = 0;
		@(negedge clk);
		unit_valid <= 1'b0;
		while (sb.expected_words.size() != 0 && n < HANG_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (6) @(posedge clk);
	endtask

	// Ordinary character: half printable letters, half anywhere in the 16-bit
	// range except the four special characters
	function automatic logic [15:0] plain_char();
		logic [15:0] c;
		if ($urandom_range(0, 1) == 0)
			return 16'h0061 + 16'($urandom_range(0, 25));
		do
			c = 16'($urandom);
		while (c == CH_LBRACE || c == CH_RBRACE || c == CH_APOS || c == CH_QUOTE);
		return c;
	endfunction

	// Well-formed template: literal runs, doubled braces and braced expressions
	// with optional quoted stretches that may hide braces
	function automatic void build_good_template();
		int          parts;
		int          n;
		logic [15:0] q;
		tmpl.delete();
		parts = $urandom_range(1, 3);
		for (int p = 0; p < parts; p++) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						tmpl.push_back(plain_char());
				end
				2: begin
					q = $urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE;
					tmpl.push_back(q);
					tmpl.push_back(q);
				end
				default: begin
					tmpl.push_back(CH_LBRACE);
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 2) == 0) begin
							q = $urandom_range(0, 1) ? CH_APOS : CH_QUOTE;
							tmpl.push_back(q);
							for (int k = $urandom_range(0, 2); k > 0; k--) begin
								case ($urandom_range(0, 3))
									0: tmpl.push_back(CH_LBRACE);
									1: tmpl.push_back(CH_RBRACE);
									2: tmpl.push_back(q == CH_APOS ? CH_QUOTE : CH_APOS);
									default: tmpl.push_back(plain_char());
								endcase
							end
							tmpl.push_back(q);
						end else begin
							tmpl.push_back(plain_char());
						end
					end
					tmpl.push_back(CH_RBRACE);
				end
			endcase
		end
	endfunction

	// Noise: heavy on special characters, mostly malformed
	function automatic void build_noise_template();
		int len;
		tmpl.delete();
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 4))
				0: tmpl.push_back(CH_LBRACE);
				1: tmpl.push_back(CH_RBRACE);
				2: tmpl.push_back(CH_APOS);
				3: tmpl.push_back(CH_QUOTE);
				default: tmpl.push_back(plain_char());
			endcase
		end
	endfunction

	task automatic send_random_until(input int unsigned target);
		while (units_parsed < target) begin
			if ($urandom_range(0, 3) == 0)
				build_noise_template();
			else
				build_good_template();
			send_template();
		end
	endtask

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		unit_valid   = 1'b0;
		unit_data    = '0;
		tx_gaps      = 1'b1;
		rx_gaps      = 1'b1;
		hold_req     = 1'b0;
		units_parsed = 0;
		idle_cycles  = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: single-unit templates (special char and all-ones char),
		// plain expression, doubled braces, empty expression, braces hidden by
		// quotes, unmatched right brace with discard, left brace inside an
		// expression, trailing right brace, unterminated quote.
		send_text("{");
		tmpl.delete();
		tmpl.push_back(16'hFFFF);
		send_template();
		tmpl.delete();
		tmpl.push_back(16'h0000);
		tmpl.push_back(CH_LBRACE);
		tmpl.push_back(16'h0062);
		tmpl.push_back(CH_RBRACE);
		send_template();
		send_text("{{}}");
		send_text("{}");
		send_text("{'}'}");
		send_text("}xy");
		send_text("{a{z");
		send_text("a}");
		send_text("{\"a");

		// Sender pause: nothing offered until the block has emptied
		wait_drained();

		send_random_until(60);

		// Receiver holds off while the sender keeps offering, so the block
		// fills and drops unit_ready
		hold_req = 1'b1;
		send_random_until(90);
		wait_drained();

		send_random_until(130);

		// Closing stretch at full rate on both sides
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_random_until(165);

		wait_drained();
		if (sb.expected_words.size() != 0) begin
			$error("%0d result words never arrived", sb.expected_words.size());
			sb.fails++;
		end
		if (sb.fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
